FILE: hw/rtl/pnm_raster_sample_decoder_unit_assert.svh
// assertion macros of the pnm raster decoder checker
`ifndef PNM_RASTER_SAMPLE_DECODER_UNIT_ASSERT_SVH
`define PNM_RASTER_SAMPLE_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define PNM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define PNM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/pnm_pkg.sv
// shared types and constants of the pnm raster sample decoder
package pnm_pkg;

	// format codes
	localparam logic [2:0] FMT_P1 = 3'd0;
	localparam logic [2:0] FMT_P2 = 3'd1;
	localparam logic [2:0] FMT_P3 = 3'd2;
	localparam logic [2:0] FMT_P4 = 3'd3;
	localparam logic [2:0] FMT_P5 = 3'd4;
	localparam logic [2:0] FMT_P6 = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_FORMAT = 2'd0;
	localparam logic [1:0] CFG_MAXVAL = 2'd1;
	localparam logic [1:0] CFG_PIXELS = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_SHORT = 2'd1;
	localparam logic [1:0] ERR_BAD   = 2'd2;

	// channel codes
	localparam logic [1:0] CH_RED  = 2'd0;
	localparam logic [1:0] CH_BLUE = 2'd2;

	// ascii characters
	localparam logic [7:0] CHR_0 = 8'h30;
	localparam logic [7:0] CHR_1 = 8'h31;
	localparam logic [7:0] CHR_9 = 8'h39;

	// widths and limits
	localparam int         PIX_W      = 25;
	localparam int         TOK_W      = 10;
	localparam logic [PIX_W-1:0] MAX_PIXELS = 25'd16777216;
	localparam logic [TOK_W-1:0] TOK_SAT    = 10'd1023;
	localparam logic [7:0] SAMPLE_FULL = 8'd255;
	localparam int         DIV_STEPS  = 8;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SAMPLE,
		ST_DIV,
		ST_EMIT,
		ST_EOD
	} pnm_state_t;

	// divider request and status
	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [7:0]  divisor;
	} pnm_div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quotient;
	} pnm_div_sts_t;

endpackage

FILE: hw/rtl/pnm_ifs.sv
// stream and configuration interfaces of the pnm raster sample decoder
interface pnm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_data;

	modport source (output valid, output byte_in, output end_of_data, input ready);
	modport sink   (input valid, input byte_in, input end_of_data, output ready);
endinterface

interface pnm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample;
	logic [1:0] channel;
	logic       pixel_done;
	logic       last;
	logic [1:0] error;

	modport source (output valid, output sample, output channel, output pixel_done,
		output last, output error, input ready);
	modport sink   (input valid, input sample, input channel, input pixel_done,
		input last, input error, output ready);
endinterface

interface pnm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [24:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/pnm_raster_sample_decoder_unit.sv
// top level of the pnm raster sample decoder
// Decodes the raster body of a P1..P6 image, one request byte at a time; software writes
// format, maximum value and pixel count beforehand. The input is taken only when the
// sequencer is idle, and a result waits in the output register while the next byte comes
// in; a result that finds that register still full holds the sequencer until it drains.
// A byte that yields no sample returns to idle; a bit sample (P1, P4) needs no division,
// and a P4 byte yields up to eight of them; a scaled sample (P2, P3, P5, P6) goes through the
// shared divider that resolves value*255/max_value one quotient bit per cycle over eight
// steps, while a value above the maximum is clamped without division.
// At end of data the state clears for the next image.
module pnm_raster_sample_decoder_unit (
	input  logic      clk,
	input  logic      arst_n,
	pnm_in_if.sink    in_ch,
	pnm_out_if.source out_ch,
	pnm_cfg_if.sink   cfg
);
	import pnm_pkg::*;

	// sequencer and image state
	pnm_state_t       state_q, state_d;
	logic [2:0]       fmt_q;
	logic [7:0]       max_q;
	logic [PIX_W-1:0] pcount_q;
	logic [TOK_W-1:0] tok_q;
	logic [1:0]       dig_q;
	logic [1:0]       ci_q;
	logic [PIX_W-1:0] pix_q;
	logic             img_done_q;
	logic             eod_q;
	logic             bit_q;
	logic             rgb_q;
	logic             multi_q;
	logic [2:0]       k_q;
	logic             out_valid_q;

	// payload registers
	logic [7:0]       byte_q;
	logic [TOK_W-1:0] val_q;
	logic [7:0]       samp_q;
	logic [7:0]       o_sample_q;
	logic [1:0]       o_ch_q;
	logic             o_pd_q;
	logic             o_last_q;
	logic [1:0]       o_err_q;

	// combinational helpers
	logic [PIX_W-1:0] lim;
	logic             accept;
	logic             slot_free;
	logic             suppress;
	logic             ascii_c;
	logic             is_digit;
	logic [3:0]       dig_val;
	logic [TOK_W-1:0] tok_next;
	logic             tok_flush;
	logic [TOK_W-1:0] v_cur;
	logic [7:0]       m_eff;
	logic             over;
	logic             need_div;
	logic [7:0]       samp_now;
	logic [1:0]       err_now;
	logic [1:0]       ch_c;
	logic             done_c;
	logic [1:0]       ci_nxt;
	logic [PIX_W-1:0] pd_nxt;
	logic             cmpl_nxt;
	logic             more_c;
	logic             short_c;
	pnm_state_t       adv_state;
	logic             adv_c;
	logic             emit_c;
	logic [7:0]       e_sample;
	logic [1:0]       e_ch;
	logic             e_pd;
	logic             e_last;
	logic [1:0]       e_err;
	pnm_div_req_t     div_req;
	pnm_div_sts_t     div_sts;

	// pixel limit, capped
	assign lim = (pcount_q > MAX_PIXELS) ? MAX_PIXELS : pcount_q;

	// handshakes
	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;
	assign slot_free   = !out_valid_q || out_ch.ready;

	// token gathering
	assign ascii_c   = (fmt_q == FMT_P2) || (fmt_q == FMT_P3);
	assign is_digit  = (byte_q >= CHR_0) && (byte_q <= CHR_9);
	assign dig_val   = 4'(byte_q - CHR_0);
	assign tok_next  = {tok_q[6:0], 3'b000} + {tok_q[8:0], 1'b0} + {6'd0, dig_val};
	assign tok_flush = ascii_c && (dig_q != 2'd0);

	// sample value and scaling checks
	assign suppress = img_done_q || (pix_q >= lim);
	assign v_cur    = multi_q ? {{(TOK_W-1){1'b0}}, byte_q[k_q]} : val_q;
	assign m_eff    = (max_q == 8'd0) ? 8'd1 : max_q;
	assign over     = v_cur > {2'b00, m_eff};
	assign need_div = !bit_q && !over;
	assign samp_now = bit_q ? {7'd0, v_cur[0]} : SAMPLE_FULL;
	assign err_now  = bit_q ? ERR_NONE : ERR_BAD;

	// channel rotation and pixel count
	assign ch_c     = !rgb_q ? CH_RED : ((ci_q == 2'd3) ? CH_RED : ci_q);
	assign done_c   = !rgb_q || (ch_c == CH_BLUE);
	assign ci_nxt   = !rgb_q ? ci_q : (done_c ? 2'd0 : ch_c + 2'd1);
	assign pd_nxt   = done_c ? pix_q + 25'd1 : pix_q;
	assign cmpl_nxt = done_c && (pd_nxt >= lim);
	assign more_c   = (multi_q && (k_q != 3'd0) && !cmpl_nxt) || (eod_q && (pd_nxt < lim));
	assign short_c  = pix_q < lim;

	// where to go once the current sample is dealt with
	assign adv_state = (multi_q && (k_q != 3'd0)) ? ST_SAMPLE : (eod_q ? ST_EOD : ST_IDLE);

	// divider request
	assign div_req.start    = (state_q == ST_SAMPLE) && !suppress && need_div;
	assign div_req.dividend = {v_cur[7:0], 8'd0} - {8'd0, v_cur[7:0]};
	assign div_req.divisor  = m_eff;

	pnm_scale_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	// next state and result selection
	always_comb begin
		state_d  = state_q;
		emit_c   = 1'b0;
		adv_c    = 1'b0;
		e_sample = samp_now;
		e_ch     = ch_c;
		e_pd     = done_c;
		e_last   = !more_c;
		e_err    = err_now;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (eod_q) begin
					state_d = tok_flush ? ST_SAMPLE : ST_EOD;
				end else begin
					unique case (fmt_q) inside
						FMT_P1: begin
							state_d = ((byte_q == CHR_0) || (byte_q == CHR_1)) ? ST_SAMPLE : ST_IDLE;
						end
						FMT_P2, FMT_P3: begin
							state_d = (!is_digit && (dig_q != 2'd0)) ? ST_SAMPLE : ST_IDLE;
						end
						FMT_P4, FMT_P5, FMT_P6: begin
							state_d = ST_SAMPLE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SAMPLE: begin
				if (suppress) begin
					adv_c   = 1'b1;
					state_d = adv_state;
				end else if (need_div) begin
					state_d = ST_DIV;
				end else if (slot_free) begin
					emit_c  = 1'b1;
					adv_c   = 1'b1;
					state_d = adv_state;
				end
			end
			ST_DIV: begin
				if (div_sts.done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				e_sample = samp_q;
				e_err    = ERR_NONE;
				if (slot_free) begin
					emit_c  = 1'b1;
					adv_c   = 1'b1;
					state_d = adv_state;
				end
			end
			ST_EOD: begin
				e_sample = 8'd0;
				e_ch     = CH_RED;
				e_pd     = 1'b0;
				e_last   = 1'b1;
				e_err    = ERR_SHORT;
				if (!short_c || slot_free) begin
					emit_c  = short_c;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// control and image state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q       <= FMT_P1;
			max_q       <= 8'd255;
			pcount_q    <= 25'd1;
			tok_q       <= '0;
			dig_q       <= '0;
			ci_q        <= '0;
			pix_q       <= '0;
			img_done_q  <= 1'b0;
			eod_q       <= 1'b0;
			bit_q       <= 1'b0;
			rgb_q       <= 1'b0;
			multi_q     <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// register writes
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_FORMAT: fmt_q    <= cfg.data[2:0];
					CFG_MAXVAL: max_q    <= cfg.data[7:0];
					CFG_PIXELS: pcount_q <= cfg.data;
					default: ;
				endcase
			end

			// request capture
			if (accept) eod_q <= in_ch.end_of_data;

			// byte decode and token update
			if (state_q == ST_DECODE) begin
				bit_q   <= !eod_q && ((fmt_q == FMT_P1) || (fmt_q == FMT_P4));
				rgb_q   <= (fmt_q == FMT_P3) || (fmt_q == FMT_P6);
				multi_q <= !eod_q && (fmt_q == FMT_P4);
				k_q     <= 3'd7;
				if (!eod_q && ascii_c) begin
					if (is_digit) begin
						if (dig_q != 2'd3) begin
							tok_q <= tok_next;
							dig_q <= dig_q + 2'd1;
						end else begin
							tok_q <= TOK_SAT;
						end
					end else if (dig_q != 2'd0) begin
						tok_q <= '0;
						dig_q <= '0;
					end
				end
			end

			// pixel accounting on each sample result
			if (emit_c && (state_q != ST_EOD)) begin
				ci_q       <= ci_nxt;
				pix_q      <= pd_nxt;
				img_done_q <= cmpl_nxt;
			end
			if (adv_c && (k_q != 3'd0)) k_q <= k_q - 3'd1;

			// end of image clears the token, channel and pixel state
			if ((state_q == ST_EOD) && (state_d == ST_IDLE)) begin
				tok_q      <= '0;
				dig_q      <= '0;
				ci_q       <= '0;
				pix_q      <= '0;
				img_done_q <= 1'b0;
			end

			// output register occupancy
			if (emit_c)            out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) byte_q <= in_ch.byte_in;
		if (state_q == ST_DECODE) begin
			if (eod_q || ascii_c)   val_q <= tok_q;
			else if (fmt_q == FMT_P1) val_q <= {{(TOK_W-1){1'b0}}, (byte_q == CHR_1)};
			else                    val_q <= {2'b00, byte_q};
		end
		if ((state_q == ST_DIV) && div_sts.done) samp_q <= div_sts.quotient;
		if (emit_c) begin
			o_sample_q <= e_sample;
			o_ch_q     <= e_ch;
			o_pd_q     <= e_pd;
			o_last_q   <= e_last;
			o_err_q    <= e_err;
		end
	end

	// result port
	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample     = o_sample_q;
	assign out_ch.channel    = o_ch_q;
	assign out_ch.pixel_done = o_pd_q;
	assign out_ch.last       = o_last_q;
	assign out_ch.error      = o_err_q;

endmodule

FILE: hw/rtl/pnm_scale_div.sv
// eight-step restoring divider for the sample scaling
module pnm_scale_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pnm_pkg::pnm_div_req_t req,
	output pnm_pkg::pnm_div_sts_t sts
);
	import pnm_pkg::*;

	logic       busy_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [7:0] rem_q;
	logic [7:0] lo_q;
	logic [7:0] den_q;
	logic [7:0] quo_q;
	logic [8:0] trial;
	logic [8:0] diff;
	logic       ge;

	// one quotient bit per step
	assign trial = {rem_q, lo_q[7]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 3'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 3'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[15:8];
			lo_q  <= req.dividend[7:0];
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[7:0] : trial[7:0];
			lo_q  <= {lo_q[6:0], 1'b0};
			quo_q <= {quo_q[6:0], ge};
		end
	end

	assign sts.done     = done_q;
	assign sts.quotient = quo_q;

endmodule

FILE: hw/rtl/pnm_checker.sv
// port-level checks of the pnm raster sample decoder and their binding
`include "pnm_raster_sample_decoder_unit_assert.svh"

module pnm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] sample,
	input logic [1:0] channel,
	input logic       pixel_done,
	input logic       last,
	input logic [1:0] error
);
	import pnm_pkg::*;

	// a stalled result keeps its payload
	`PNM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample) && $stable(channel) && $stable(error) && $stable(last), "stalled result changed")

	// a byte is decoded before the next request is taken
	`PNM_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while decoding")

	// the short-image flag stands alone as the final result
	`PNM_ASSERT_NOW(a_short_shape, out_valid && (error == ERR_SHORT), (sample == 8'd0) && (channel == CH_RED) && !pixel_done && last, "malformed short-image result")

	// a bad token or value is clamped to full scale
	`PNM_ASSERT_NOW(a_bad_clamp, out_valid && (error == ERR_BAD), sample == SAMPLE_FULL, "bad value not clamped")

endmodule

bind pnm_raster_sample_decoder_unit pnm_checker u_pnm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.sample     (out_ch.sample),
	.channel    (out_ch.channel),
	.pixel_done (out_ch.pixel_done),
	.last       (out_ch.last),
	.error      (out_ch.error)
);
